// ===== sv/forest_ruth_motion_integrator_defines.svh =====
// Assertion helpers for the motion integrator.
`ifndef FOREST_RUTH_MOTION_INTEGRATOR_DEFINES_SVH
`define FOREST_RUTH_MOTION_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define FRMI_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRMI_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/frmi_pkg.sv =====
package frmi_pkg;

    localparam int DW         = 32;   // position / velocity / acceleration width
    localparam int TW         = 16;   // time step width, Q0.16
    localparam int HW         = 31;   // substep magnitude width, Q1.30
    localparam int STEP_FRAC  = 30;
    localparam int TS_FRAC    = 16;
    localparam int DT_SHIFT   = STEP_FRAC - TS_FRAC;
    localparam int SH_FULL    = STEP_FRAC;
    localparam int SH_HALF    = STEP_FRAC + 1;
    localparam int NUM_AXES   = 3;
    localparam int NUM_SLOTS  = 6;

    // c and |1-2c| in Q1.30
    localparam logic [HW-1:0] COEF_C = 31'd1450847675;
    localparam logic [HW-1:0] COEF_K = 31'd1827953526;

    typedef logic signed [DW-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_FR     = 2'd0,
        MODE_VERLET = 2'd1,
        MODE_EULER  = 2'd2
    } mode_t;

    typedef struct packed {
        word_t           pos_x;
        word_t           pos_y;
        word_t           pos_z;
        word_t           vel_x;
        word_t           vel_y;
        word_t           vel_z;
        word_t           acc_x;
        word_t           acc_y;
        word_t           acc_z;
        logic [TW-1:0]   time_step;
    } item_t;

    typedef struct packed {
        word_t new_pos_x;
        word_t new_pos_y;
        word_t new_pos_z;
        word_t new_vel_x;
        word_t new_vel_y;
        word_t new_vel_z;
    } result_t;

    // signed substep as sign and magnitude
    typedef struct packed {
        logic          neg;
        logic [HW-1:0] mag;
    } step_t;

    typedef struct packed {
        mode_t         mode;
        logic [TW-1:0] dt;
        logic [HW-1:0] hc;   // c*dt
        logic [HW-1:0] hk;   // |(1-2c)*dt|, negative
    } side_t;

    typedef struct packed {
        word_t [NUM_AXES-1:0] pos;
        word_t [NUM_AXES-1:0] vel;
        word_t [NUM_AXES-1:0] acc;
        side_t                side;
    } body_t;

    // Substep applied by a slot. Position ops shift by 31 (half step),
    // velocity ops by 30. Velocity updates only happen in even slots.
    function automatic step_t slot_step(input side_t sd, input int slot, input logic vel_op);
        step_t         s;
        logic [HW-1:0] full;
        logic [HW-1:0] full2;
        full  = HW'({sd.dt, {DT_SHIFT{1'b0}}});
        full2 = HW'({sd.dt, {(DT_SHIFT + 1){1'b0}}});
        s.neg = 1'b0;
        s.mag = '0;
        unique case (sd.mode)
            MODE_VERLET:
            begin
                if (slot == 0 || (slot == 1 && !vel_op))
                begin
                    s.mag = full;
                end
            end
            MODE_EULER:
            begin
                // velocity first, then position by the new velocity, full step
                if (vel_op && slot == 0)
                begin
                    s.mag = full;
                end
                else if (!vel_op && slot == 1)
                begin
                    s.mag = full2;
                end
            end
            default:
            begin
                if (!vel_op || slot == 0 || slot == 2 || slot == 4)
                begin
                    if (slot == 2 || slot == 3)
                    begin
                        s.neg = 1'b1;
                        s.mag = sd.hk;
                    end
                    else
                    begin
                        s.mag = sd.hc;
                    end
                end
            end
        endcase
        return s;
    endfunction

    // base +/- mag, clamped to the signed word range
    function automatic word_t sat_add(input word_t base, input logic [DW:0] mag, input logic neg);
        logic signed [DW+2:0] wide;
        logic signed [DW+2:0] addend;
        word_t                res;
        addend = $signed({2'b00, mag});
        wide   = $signed({{3{base[DW-1]}}, base});
        wide   = neg ? (wide - addend) : (wide + addend);
        if (wide[DW+2:DW-1] == '0 || wide[DW+2:DW-1] == '1)
        begin
            res = wide[DW-1:0];
        end
        else if (wide[DW+2])
        begin
            res = WORD_MIN;
        end
        else
        begin
            res = WORD_MAX;
        end
        return res;
    endfunction

endpackage

// ===== sv/frmi_slot.sv =====
// One integration slot: stage A multiplies with the rounding bias, stage B shifts and saturates.
module frmi_slot #(
    parameter int SLOT = 0
) (
    input  logic            clk,
    input  logic [1:0]      ld,
    input  frmi_pkg::body_t d_in,
    output frmi_pkg::body_t d_out
);

    localparam int PW = frmi_pkg::DW + frmi_pkg::HW;
    localparam logic [PW-1:0] RND_HALF = PW'(1) << (frmi_pkg::SH_HALF - 1);
    localparam logic [PW-1:0] RND_FULL = PW'(1) << (frmi_pkg::SH_FULL - 1);

    frmi_pkg::step_t             hp;
    frmi_pkg::step_t             hv;
    logic [frmi_pkg::DW-1:0]     vmag [frmi_pkg::NUM_AXES];
    logic [frmi_pkg::DW-1:0]     amag [frmi_pkg::NUM_AXES];
    logic [PW-1:0]               pprod_next [frmi_pkg::NUM_AXES];
    logic [PW-1:0]               pprod_reg  [frmi_pkg::NUM_AXES];
    logic [PW-1:0]               vprod_next [frmi_pkg::NUM_AXES];
    logic [PW-1:0]               vprod_reg  [frmi_pkg::NUM_AXES];
    logic [frmi_pkg::NUM_AXES-1:0] pneg_next;
    logic [frmi_pkg::NUM_AXES-1:0] pneg_reg;
    logic [frmi_pkg::NUM_AXES-1:0] vneg_next;
    logic [frmi_pkg::NUM_AXES-1:0] vneg_reg;
    frmi_pkg::body_t             mid_reg;
    frmi_pkg::body_t             out_next;
    frmi_pkg::body_t             out_reg;

    // stage A: exact magnitude products with the rounding bias folded in
    always_comb
    begin
        hp = frmi_pkg::slot_step(d_in.side, SLOT, 1'b0);
        hv = frmi_pkg::slot_step(d_in.side, SLOT, 1'b1);
        for (int ax = 0; ax < frmi_pkg::NUM_AXES; ax++)
        begin
            vmag[ax] = d_in.vel[ax][frmi_pkg::DW-1] ? (~d_in.vel[ax] + 1'b1) : d_in.vel[ax];
            amag[ax] = d_in.acc[ax][frmi_pkg::DW-1] ? (~d_in.acc[ax] + 1'b1) : d_in.acc[ax];
            pprod_next[ax] = PW'(vmag[ax]) * PW'(hp.mag) + RND_HALF;
            vprod_next[ax] = PW'(amag[ax]) * PW'(hv.mag) + RND_FULL;
            pneg_next[ax]  = d_in.vel[ax][frmi_pkg::DW-1] ^ hp.neg;
            vneg_next[ax]  = d_in.acc[ax][frmi_pkg::DW-1] ^ hv.neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            mid_reg   <= d_in;
            pprod_reg <= pprod_next;
            vprod_reg <= vprod_next;
            pneg_reg  <= pneg_next;
            vneg_reg  <= vneg_next;
        end
    end

    // stage B: position uses the velocity from before this slot's update
    always_comb
    begin
        out_next = mid_reg;
        for (int ax = 0; ax < frmi_pkg::NUM_AXES; ax++)
        begin
            out_next.pos[ax] = frmi_pkg::sat_add(mid_reg.pos[ax],
                {1'b0, pprod_reg[ax][PW-1:frmi_pkg::SH_HALF]}, pneg_reg[ax]);
            out_next.vel[ax] = frmi_pkg::sat_add(mid_reg.vel[ax],
                vprod_reg[ax][PW-1:frmi_pkg::SH_FULL], vneg_reg[ax]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

// ===== sv/forest_ruth_motion_integrator.sv =====
// Channel   Direction  Signals                                    Payload
// item      in         item_valid / item_ready / item             frmi_pkg::item_t
// result    out        result_valid / result_ready / result       frmi_pkg::result_t
// cfg       in         cfg_valid / cfg_ready / cfg_data           integrator_mode, 2 bits
//
// One transaction per cycle while result_ready is high; each passes an entry stage
// plus six two-stage slots (a multiply stage, then a shift/saturate stage).
// rst_n clears the valid bits and integrator_mode (Forest-Ruth); data regs hold.
// Stalls: each stage loads when it is empty or the stage after it moves, so a
// stalled result still lets items fill bubbles upstream; nothing is dropped.
// cfg_ready is always high; write the mode only while the pipeline is empty.
`include "forest_ruth_motion_integrator_defines.svh"

module forest_ruth_motion_integrator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  frmi_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_ready,
    output frmi_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);

    localparam int NSTG    = 1 + 2 * frmi_pkg::NUM_SLOTS;
    localparam int SCALE_W = frmi_pkg::TW + frmi_pkg::HW;
    localparam logic [SCALE_W-1:0] SCALE_RND = SCALE_W'(1) << (frmi_pkg::TS_FRAC - 1);

    logic [1:0]          mode_reg;
    frmi_pkg::mode_t     mode_eff;
    logic [NSTG-1:0]     vld_reg;
    logic [NSTG-1:0]     load;
    logic [SCALE_W-1:0]  hc_prod;
    logic [SCALE_W-1:0]  hk_prod;
    frmi_pkg::body_t     body0_next;
    frmi_pkg::body_t     body0_reg;
    frmi_pkg::body_t     slot_in  [frmi_pkg::NUM_SLOTS];
    frmi_pkg::body_t     slot_out [frmi_pkg::NUM_SLOTS];
    logic                in_acc;
    logic                out_acc;

    // ---------------------------------------------------------------
    // Configuration: mode register, always ready
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= frmi_pkg::MODE_FR;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // unused code 3 runs Forest-Ruth
    always_comb
    begin
        unique case (mode_reg)
            frmi_pkg::MODE_VERLET: mode_eff = frmi_pkg::MODE_VERLET;
            frmi_pkg::MODE_EULER:  mode_eff = frmi_pkg::MODE_EULER;
            default:               mode_eff = frmi_pkg::MODE_FR;
        endcase
    end

    // ---------------------------------------------------------------
    // Flow control: a stage loads when empty or when everything after it
    // can advance. Prefix-AND of the valid bits, no state.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < NSTG; i++)
    begin : g_load
        assign load[i] = result_ready || !(&vld_reg[NSTG-1:i]);
    end

    assign item_ready   = load[0];
    assign result_valid = vld_reg[NSTG-1];
    assign in_acc       = item_valid && item_ready;
    assign out_acc      = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                vld_reg[0] <= item_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Entry stage: substep lengths c*dt and |(1-2c)*dt| in Q1.30,
    // rounded to nearest (both are magnitudes, so ties go away from zero)
    // ---------------------------------------------------------------
    always_comb
    begin
        hc_prod = SCALE_W'(item.time_step) * SCALE_W'(frmi_pkg::COEF_C) + SCALE_RND;
        hk_prod = SCALE_W'(item.time_step) * SCALE_W'(frmi_pkg::COEF_K) + SCALE_RND;

        body0_next.pos[0]   = item.pos_x;
        body0_next.pos[1]   = item.pos_y;
        body0_next.pos[2]   = item.pos_z;
        body0_next.vel[0]   = item.vel_x;
        body0_next.vel[1]   = item.vel_y;
        body0_next.vel[2]   = item.vel_z;
        body0_next.acc[0]   = item.acc_x;
        body0_next.acc[1]   = item.acc_y;
        body0_next.acc[2]   = item.acc_z;
        body0_next.side.mode = mode_eff;
        body0_next.side.dt   = item.time_step;
        body0_next.side.hc   = hc_prod[SCALE_W-1:frmi_pkg::TS_FRAC];
        body0_next.side.hk   = hk_prod[SCALE_W-1:frmi_pkg::TS_FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            body0_reg <= body0_next;
        end
    end

    // ---------------------------------------------------------------
    // Six slots. Forest-Ruth: position gets h1,h1,h2,h2,h3,h3 half steps,
    // velocity gets h1,h2,h3 in slots 0,2,4. Verlet uses slots 0-1, Euler
    // slot 0 (velocity) and slot 1 (position); the rest pass through.
    // ---------------------------------------------------------------
    for (genvar s = 0; s < frmi_pkg::NUM_SLOTS; s++)
    begin : g_slot
        if (s == 0)
        begin : g_first
            assign slot_in[s] = body0_reg;
        end
        else
        begin : g_next
            assign slot_in[s] = slot_out[s-1];
        end

        frmi_slot #(
            .SLOT (s)
        ) u_slot (
            .clk   (clk),
            .ld    ({load[2 + 2 * s], load[1 + 2 * s]}),
            .d_in  (slot_in[s]),
            .d_out (slot_out[s])
        );
    end

    // ---------------------------------------------------------------
    // Result
    // ---------------------------------------------------------------
    always_comb
    begin
        result.new_pos_x = slot_out[frmi_pkg::NUM_SLOTS-1].pos[0];
        result.new_pos_y = slot_out[frmi_pkg::NUM_SLOTS-1].pos[1];
        result.new_pos_z = slot_out[frmi_pkg::NUM_SLOTS-1].pos[2];
        result.new_vel_x = slot_out[frmi_pkg::NUM_SLOTS-1].vel[0];
        result.new_vel_y = slot_out[frmi_pkg::NUM_SLOTS-1].vel[1];
        result.new_vel_z = slot_out[frmi_pkg::NUM_SLOTS-1].vel[2];
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FRMI_ASSERT_NEXT(a_entry_valid, clk, rst_n, in_acc, vld_reg[0], "accepted transaction lost at entry")
    `FRMI_ASSERT_SAME(a_ready_full, clk, rst_n, !item_ready, (&vld_reg) && !result_ready, "input stalled with a bubble in flight")
    `FRMI_ASSERT_SAME(a_occupancy, clk, rst_n, $past(rst_n), $countones(vld_reg) == $past($countones(vld_reg)) + $past(in_acc) - $past(out_acc), "pipeline occupancy does not match transactions")

endmodule
